FILE: design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg - descriptor slot allocator shared definitions
// Field widths, operation and status codes, register indexes and the control
// bundle that drives one free list.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned SLOT_W    = 11;
  localparam int unsigned STRIDE_W  = 11;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned FENCE_W   = 64;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PROD_W    = SLOT_W + STRIDE_W;

  localparam int unsigned PERSISTENT_DEPTH_DEF = 1024;
  localparam int unsigned TEMPORARY_DEPTH_DEF  = 1024;

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC_P = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE_P  = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_T = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PERSIST   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_TEMP      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TCOUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE  = 3'd5;

  localparam logic [SLOT_W-1:0]  FAIL_SLOT       = '1;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 11'd32;

  typedef struct packed {
    logic              rebuild;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } fl_ctrl_t;

endpackage

FILE: design/dsa_ram.sv
// ----------------------------------------------------------------------------
// dsa_ram - generic single write port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dsa_free_list.sv
// ----------------------------------------------------------------------------
// dsa_free_list - ring of free slot numbers
// Ring in RAM with head and count. After a rebuild, positions below the
// initial count read as base plus position until the tail overwrites them,
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dsa_free_list #(
  parameter int unsigned DEPTH = dsa_pkg::PERSISTENT_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsa_pkg::fl_ctrl_t         ctrl_i,
  input  logic [CW-1:0]             init_count_i,
  input  logic [dsa_pkg::SLOT_W-1:0] init_base_i,
  output logic [CW-1:0]             count_o,
  output logic [dsa_pkg::SLOT_W-1:0] head_slot_o
);
  import dsa_pkg::*;

  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     lim_q, lim_d;
  logic [CW-1:0]     ovr_q, ovr_d;
  logic [SLOT_W-1:0] base_q, base_d;

  logic [CW:0]       tail_sum;
  logic [CW:0]       tail_wrap;
  logic [CW-1:0]     tail_cw;
  logic [AW-1:0]     tail_idx;
  logic [CW-1:0]     head_cw;
  logic              init_hit;
  logic [SLOT_W-1:0] rdata;

  assign tail_sum  = {1'b0, CW'(head_q)} + {1'b0, count_q};
  assign tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
  assign tail_cw   = tail_wrap[CW-1:0];
  assign tail_idx  = tail_wrap[AW-1:0];
  assign head_cw   = CW'(head_q);

  // untouched low positions still hold their rebuild value
  assign init_hit    = (head_cw < lim_q) && (head_cw >= ovr_q);
  assign head_slot_o = init_hit ? base_q + SLOT_W'(head_q) : rdata;
  assign count_o     = count_q;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    lim_d   = lim_q;
    ovr_d   = ovr_q;
    base_d  = base_q;
    if (ctrl_i.rebuild) begin
      head_d  = '0;
      count_d = init_count_i;
      lim_d   = init_count_i;
      ovr_d   = '0;
      base_d  = init_base_i;
    end else begin
      if (ctrl_i.pop) begin
        head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (ctrl_i.push && !ctrl_i.pop) begin
        count_d = count_q + 1'b1;
      end else if (ctrl_i.pop && !ctrl_i.push) begin
        count_d = count_q - 1'b1;
      end
      if (ctrl_i.push && (tail_cw < lim_q) && (tail_cw >= ovr_q)) begin
        ovr_d = tail_cw + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      lim_q   <= '0;
      ovr_q   <= '0;
      base_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      lim_q   <= lim_d;
      ovr_q   <= ovr_d;
      base_q  <= base_d;
    end
  end

  dsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push && !ctrl_i.rebuild),
    .waddr_i (tail_idx),
    .wdata_i (ctrl_i.push_slot),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

endmodule

FILE: design/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator - persistent and temporary descriptor slot lists
// Hands out slots from two free rings; temporary slots come back through a
// fence-tagged release queue that is drained when the temporary ring is empty.
//
//   channel   handshake              payload
//   request   in_valid_i/in_stall_o  operation, free slot, handle flag, fences
//   result    out_valid_o/out_stall_i status, slot, cpu and gpu address
//   config    cfg_we_i               cfg_index_i, cfg_data_i
//
// A persistent allocation passes dispatch, RAM read, multiply and finish; a temporary
// one adds a full check after dispatch. A free or an empty persistent ring goes from
// dispatch to finish, a temporary refusal from the full check; the block then goes idle
// and takes the next request. On an empty temporary ring each release entry checked adds
// a queue RAM read and a fence compare, plus a last read when the queue runs dry or the
// ring fills. Reset empties both lists; a count write rebuilds them. Requests stall while
// busy; a result held by out_stall_i blocks the next one at the finish step.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator #(
  parameter int unsigned PERSISTENT_DEPTH = dsa_pkg::PERSISTENT_DEPTH_DEF,
  parameter int unsigned TEMPORARY_DEPTH  = dsa_pkg::TEMPORARY_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dsa_pkg::OP_W-1:0]      operation_i,
  input  logic [dsa_pkg::SLOT_W-1:0]    free_slot_i,
  input  logic                          free_handle_valid_i,
  input  logic [dsa_pkg::FENCE_W-1:0]   fence_completed_i,
  input  logic [dsa_pkg::FENCE_W-1:0]   fence_current_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dsa_pkg::STATUS_W-1:0]  status_o,
  output logic [dsa_pkg::SLOT_W-1:0]    slot_o,
  output logic [dsa_pkg::ADDR_W-1:0]    cpu_address_o,
  output logic [dsa_pkg::ADDR_W-1:0]    gpu_address_o
);
  import dsa_pkg::*;

  localparam int unsigned PCW   = $clog2(PERSISTENT_DEPTH + 1);
  localparam int unsigned TCW   = $clog2(TEMPORARY_DEPTH + 1);
  localparam int unsigned TAW   = (TEMPORARY_DEPTH > 1) ? $clog2(TEMPORARY_DEPTH) : 1;
  localparam int unsigned REL_W = SLOT_W + FENCE_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_P_WAIT = 4'd2;
  localparam logic [3:0] S_T_REL  = 4'd3;
  localparam logic [3:0] S_T_CHK  = 4'd4;
  localparam logic [3:0] S_T_END  = 4'd5;
  localparam logic [3:0] S_T_WAIT = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  // configuration
  logic [COUNT_W-1:0]  pcount_q, pcount_d;
  logic [COUNT_W-1:0]  tcount_q, tcount_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [ADDR_W-1:0]   cpu_base_q, cpu_base_d;
  logic [ADDR_W-1:0]   gpu_base_q, gpu_base_d;
  logic                vis_q, vis_d;
  logic                rebuild;
  logic [PCW-1:0]      p_init;
  logic [TCW-1:0]      t_init;

  // sequencer
  logic [3:0]          state_q, state_d;
  logic                in_fire;
  logic                out_load;
  logic [OP_W-1:0]     op_q;
  logic [SLOT_W-1:0]   fslot_q;
  logic                fvalid_q;
  logic [FENCE_W-1:0]  done_q;
  logic [FENCE_W-1:0]  now_q;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                addr_en_q, addr_en_d;
  logic [PROD_W-1:0]   prod_q;

  // release queue
  logic [TAW-1:0]      rel_head_q, rel_head_d;
  logic [TCW-1:0]      rel_count_q, rel_count_d;
  logic [TCW:0]        rel_tail_sum;
  logic [TCW:0]        rel_tail_wrap;
  logic                rel_we;
  logic [REL_W-1:0]    rel_rdata;
  logic [SLOT_W-1:0]   rel_slot;
  logic [FENCE_W-1:0]  rel_fence;

  // free lists
  fl_ctrl_t            p_ctrl, t_ctrl;
  logic [PCW-1:0]      p_count;
  logic [TCW-1:0]      t_count;
  logic [SLOT_W-1:0]   p_head_slot;
  logic [SLOT_W-1:0]   t_head_slot;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_out_q;
  logic [SLOT_W-1:0]   slot_out_q;
  logic [ADDR_W-1:0]   cpu_out_q;
  logic [ADDR_W-1:0]   gpu_out_q;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_comb begin
    pcount_d   = pcount_q;
    tcount_d   = tcount_q;
    stride_d   = stride_q;
    cpu_base_d = cpu_base_q;
    gpu_base_d = gpu_base_q;
    vis_d      = vis_q;
    rebuild    = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PCOUNT: begin
          pcount_d = cfg_data_i[COUNT_W-1:0];
          rebuild  = 1'b1;
        end
        REG_TCOUNT: begin
          tcount_d = cfg_data_i[COUNT_W-1:0];
          rebuild  = 1'b1;
        end
        REG_STRIDE:   stride_d   = cfg_data_i[STRIDE_W-1:0];
        REG_CPU_BASE: cpu_base_d = cfg_data_i;
        REG_GPU_BASE: gpu_base_d = cfg_data_i;
        REG_VISIBLE:  vis_d      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturate counts to the ring depth
  assign p_init = (32'(pcount_d) > 32'(PERSISTENT_DEPTH)) ? PCW'(PERSISTENT_DEPTH)
                                                          : PCW'(pcount_d);
  assign t_init = (32'(tcount_d) > 32'(TEMPORARY_DEPTH)) ? TCW'(TEMPORARY_DEPTH)
                                                         : TCW'(tcount_d);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign rel_tail_sum  = {1'b0, TCW'(rel_head_q)} + {1'b0, rel_count_q};
  assign rel_tail_wrap = (rel_tail_sum >= (TCW+1)'(TEMPORARY_DEPTH))
                         ? rel_tail_sum - (TCW+1)'(TEMPORARY_DEPTH) : rel_tail_sum;
  assign rel_slot      = rel_rdata[REL_W-1:FENCE_W];
  assign rel_fence     = rel_rdata[FENCE_W-1:0];

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    slot_d       = slot_q;
    addr_en_d    = addr_en_q;
    rel_head_d   = rel_head_q;
    rel_count_d  = rel_count_q;
    rel_we       = 1'b0;
    p_ctrl       = '{rebuild: rebuild, pop: 1'b0, push: 1'b0, push_slot: fslot_q};
    t_ctrl       = '{rebuild: rebuild, pop: 1'b0, push: 1'b0, push_slot: rel_slot};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_q)
          OP_ALLOC_P: begin
            if (p_count == '0) begin
              res_status_d = STATUS_NO_PERSIST;
              slot_d       = FAIL_SLOT;
              addr_en_d    = 1'b0;
              state_d      = S_FIN;
            end else begin
              state_d = S_P_WAIT;
            end
          end
          OP_FREE_P: begin
            slot_d    = fslot_q;
            addr_en_d = 1'b0;
            state_d   = S_FIN;
            if (!fvalid_q) begin
              res_status_d = STATUS_INVALID_FREE;
            end else if (p_count == PCW'(PERSISTENT_DEPTH)) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_status_d = STATUS_OK;
              p_ctrl.push  = 1'b1;
            end
          end
          OP_ALLOC_T: begin
            state_d = (t_count == '0) ? S_T_REL : S_T_END;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_P_WAIT: begin
        slot_d       = p_head_slot;
        res_status_d = STATUS_OK;
        addr_en_d    = 1'b1;
        p_ctrl.pop   = 1'b1;
        state_d      = S_MUL;
      end
      // release queue head address settles here; data is checked next cycle
      S_T_REL: begin
        if (rel_count_q != '0 && t_count < TCW'(TEMPORARY_DEPTH)) begin
          state_d = S_T_CHK;
        end else begin
          state_d = S_T_END;
        end
      end
      S_T_CHK: begin
        if (rel_fence > done_q) begin
          state_d = S_T_END;
        end else begin
          t_ctrl.push = 1'b1;
          rel_head_d  = (rel_head_q == TAW'(TEMPORARY_DEPTH - 1)) ? '0 : rel_head_q + 1'b1;
          rel_count_d = rel_count_q - 1'b1;
          state_d     = S_T_REL;
        end
      end
      S_T_END: begin
        if (t_count == '0) begin
          res_status_d = STATUS_NO_TEMP;
          slot_d       = FAIL_SLOT;
          addr_en_d    = 1'b0;
          state_d      = S_FIN;
        end else if (rel_count_q == TCW'(TEMPORARY_DEPTH)) begin
          res_status_d = STATUS_FULL;
          slot_d       = FAIL_SLOT;
          addr_en_d    = 1'b0;
          state_d      = S_FIN;
        end else begin
          state_d = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        slot_d       = t_head_slot;
        res_status_d = STATUS_OK;
        addr_en_d    = 1'b1;
        t_ctrl.pop   = 1'b1;
        rel_we       = 1'b1;
        rel_count_d  = rel_count_q + 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a count write empties the release queue
    if (rebuild) begin
      rel_head_d  = '0;
      rel_count_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q    <= '0;
      tcount_q    <= '0;
      stride_q    <= STRIDE_RESET;
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      vis_q       <= 1'b0;
      state_q     <= S_IDLE;
      rel_head_q  <= '0;
      rel_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pcount_q    <= pcount_d;
      tcount_q    <= tcount_d;
      stride_q    <= stride_d;
      cpu_base_q  <= cpu_base_d;
      gpu_base_q  <= gpu_base_d;
      vis_q       <= vis_d;
      state_q     <= state_d;
      rel_head_q  <= rel_head_d;
      rel_count_q <= rel_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= operation_i;
      fslot_q  <= free_slot_i;
      fvalid_q <= free_handle_valid_i;
      done_q   <= fence_completed_i;
      now_q    <= fence_current_i;
    end
    res_status_q <= res_status_d;
    slot_q       <= slot_d;
    addr_en_q    <= addr_en_d;
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(slot_q) * PROD_W'(stride_q);
    end
    if (out_load) begin
      status_out_q <= res_status_q;
      slot_out_q   <= slot_q;
      cpu_out_q    <= addr_en_q ? cpu_base_q + ADDR_W'(prod_q) : '0;
      gpu_out_q    <= (addr_en_q && vis_q) ? gpu_base_q + ADDR_W'(prod_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign slot_o        = slot_out_q;
  assign cpu_address_o = cpu_out_q;
  assign gpu_address_o = gpu_out_q;

  // ---------------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------------
  dsa_free_list #(
    .DEPTH (PERSISTENT_DEPTH)
  ) u_persist_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (p_ctrl),
    .init_count_i (p_init),
    .init_base_i  ('0),
    .count_o      (p_count),
    .head_slot_o  (p_head_slot)
  );

  dsa_free_list #(
    .DEPTH (TEMPORARY_DEPTH)
  ) u_temp_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (t_ctrl),
    .init_count_i (t_init),
    .init_base_i  (pcount_d),
    .count_o      (t_count),
    .head_slot_o  (t_head_slot)
  );

  dsa_ram #(
    .WIDTH (REL_W),
    .DEPTH (TEMPORARY_DEPTH)
  ) u_release_ram (
    .clk_i   (clk_i),
    .we_i    (rel_we),
    .waddr_i (rel_tail_wrap[TAW-1:0]),
    .wdata_i ({t_head_slot, now_q}),
    .raddr_i (rel_head_q),
    .rdata_o (rel_rdata)
  );

endmodule

FILE: bench/descriptor_slot_allocator_checker.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator grant checker
// Follows register writes and accepted requests, keeps its own copy of the
// persistent ring, the temporary ring and the fence-tagged release queue, and
// compares every accepted grant field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module descriptor_slot_allocator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [dsa_pkg::OP_W-1:0]      operation_i,
  input  logic [dsa_pkg::SLOT_W-1:0]    free_slot_i,
  input  logic                          free_handle_valid_i,
  input  logic [dsa_pkg::FENCE_W-1:0]   fence_completed_i,
  input  logic [dsa_pkg::FENCE_W-1:0]   fence_current_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [dsa_pkg::STATUS_W-1:0]  status_i,
  input  logic [dsa_pkg::SLOT_W-1:0]    slot_i,
  input  logic [dsa_pkg::ADDR_W-1:0]    cpu_address_i,
  input  logic [dsa_pkg::ADDR_W-1:0]    gpu_address_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import dsa_pkg::*;

  localparam int unsigned PDEPTH = PERSISTENT_DEPTH_DEF;
  localparam int unsigned TDEPTH = TEMPORARY_DEPTH_DEF;
  localparam int unsigned PIDX_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int unsigned TIDX_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   cpu;
    logic [ADDR_W-1:0]   gpu;
  } grant_t;

  logic [COUNT_W-1:0]  pcount_q;
  logic [COUNT_W-1:0]  tcount_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [ADDR_W-1:0]   cpu_base_q;
  logic [ADDR_W-1:0]   gpu_base_q;
  logic                visible_q;

  logic [SLOT_W-1:0]  persist_ring [PDEPTH];
  int unsigned        persist_head;
  int unsigned        persist_fill;
  logic [SLOT_W-1:0]  temp_ring [TDEPTH];
  int unsigned        temp_head;
  int unsigned        temp_fill;
  logic [SLOT_W-1:0]  release_slot [TDEPTH];
  logic [FENCE_W-1:0] release_tag [TDEPTH];
  int unsigned        release_head;
  int unsigned        release_fill;

  grant_t      pending_grants [$];
  int unsigned mismatch_count;

  function automatic grant_t granted(logic [SLOT_W-1:0] s);
    grant_t            g;
    logic [ADDR_W-1:0] offset;
    offset   = ADDR_W'(s) * ADDR_W'(stride_q);
    g.status = STATUS_OK;
    g.slot   = s;
    g.cpu    = cpu_base_q + offset;
    g.gpu    = visible_q ? gpu_base_q + offset : '0;
    return g;
  endfunction

  function automatic grant_t refused(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s);
    grant_t g;
    g.status = st;
    g.slot   = s;
    g.cpu    = '0;
    g.gpu    = '0;
    return g;
  endfunction

  // Count writes refill both rings from scratch and drop the release queue.
  task automatic rebuild_lists();
    int unsigned p;
    int unsigned t;
    p = (32'(pcount_q) > PDEPTH) ? PDEPTH : 32'(pcount_q);
    t = (32'(tcount_q) > TDEPTH) ? TDEPTH : 32'(tcount_q);
    for (int unsigned i = 0; i < p; i++) persist_ring[PIDX_W'(i)] = SLOT_W'(i);
    for (int unsigned i = 0; i < t; i++) temp_ring[TIDX_W'(i)] = SLOT_W'(32'(pcount_q) + i);
    persist_head = 0;
    persist_fill = p;
    temp_head    = 0;
    temp_fill    = t;
    release_head = 0;
    release_fill = 0;
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_PCOUNT: begin
        pcount_q = data[COUNT_W-1:0];
        rebuild_lists();
      end
      REG_TCOUNT: begin
        tcount_q = data[COUNT_W-1:0];
        rebuild_lists();
      end
      REG_STRIDE:   stride_q   = data[STRIDE_W-1:0];
      REG_CPU_BASE: cpu_base_q = data[ADDR_W-1:0];
      REG_GPU_BASE: gpu_base_q = data[ADDR_W-1:0];
      REG_VISIBLE:  visible_q  = data[0];
      default: ;
    endcase
  endtask

  task automatic predict_grant(logic [OP_W-1:0] op, logic [SLOT_W-1:0] fslot, logic hv,
                               logic [FENCE_W-1:0] done, logic [FENCE_W-1:0] now);
    logic [SLOT_W-1:0] s;
    case (op)
      OP_ALLOC_P: begin
        if (persist_fill == 0) begin
          pending_grants.push_back(refused(STATUS_NO_PERSIST, FAIL_SLOT));
        end else begin
          s = persist_ring[PIDX_W'(persist_head)];
          persist_head = (persist_head + 1) % PDEPTH;
          persist_fill--;
          pending_grants.push_back(granted(s));
        end
      end
      OP_FREE_P: begin
        if (!hv) begin
          pending_grants.push_back(refused(STATUS_INVALID_FREE, fslot));
        end else if (persist_fill >= PDEPTH) begin
          pending_grants.push_back(refused(STATUS_FULL, fslot));
        end else begin
          persist_ring[PIDX_W'((persist_head + persist_fill) % PDEPTH)] = fslot;
          persist_fill++;
          pending_grants.push_back(refused(STATUS_OK, fslot));
        end
      end
      OP_ALLOC_T: begin
        // reclaim lazily: only when the ring is dry, and stop at the first young tag
        if (temp_fill == 0) begin
          while (release_fill > 0 && temp_fill < TDEPTH &&
                 release_tag[TIDX_W'(release_head)] <= done) begin
            temp_ring[TIDX_W'((temp_head + temp_fill) % TDEPTH)] =
              release_slot[TIDX_W'(release_head)];
            temp_fill++;
            release_head = (release_head + 1) % TDEPTH;
            release_fill--;
          end
        end
        if (temp_fill == 0) begin
          pending_grants.push_back(refused(STATUS_NO_TEMP, FAIL_SLOT));
        end else if (release_fill >= TDEPTH) begin
          pending_grants.push_back(refused(STATUS_FULL, FAIL_SLOT));
        end else begin
          s = temp_ring[TIDX_W'(temp_head)];
          temp_head = (temp_head + 1) % TDEPTH;
          temp_fill--;
          release_slot[TIDX_W'((release_head + release_fill) % TDEPTH)] = s;
          release_tag[TIDX_W'((release_head + release_fill) % TDEPTH)]  = now;
          release_fill++;
          pending_grants.push_back(granted(s));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_grant();
    grant_t want;
    grant_t got;
    got = '{status_i, slot_i, cpu_address_i, gpu_address_i};
    if (pending_grants.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected grant status=%h slot=%h cpu=%h gpu=%h",
                 $realtime, got.status, got.slot, got.cpu, got.gpu);
    end else begin
      want = pending_grants[0];
      pending_grants.delete(0);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: grant mismatch", $realtime);
          $display("  expected status=%h slot=%h cpu=%h gpu=%h",
                   want.status, want.slot, want.cpu, want.gpu);
          $display("  actual   status=%h slot=%h cpu=%h gpu=%h",
                   got.status, got.slot, got.cpu, got.gpu);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q       = '0;
      tcount_q       = '0;
      stride_q       = STRIDE_RESET;
      cpu_base_q     = '0;
      gpu_base_q     = '0;
      visible_q      = 1'b0;
      mismatch_count = 0;
      rebuild_lists();
      pending_grants.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) check_grant();
      if (in_valid_i && !in_stall_i)
        predict_grant(operation_i, free_slot_i, free_handle_valid_i,
                      fence_completed_i, fence_current_i);
      fail_count_o <= mismatch_count;
      pending_o    <= $unsigned(pending_grants.size());
    end
  end

endmodule

FILE: bench/descriptor_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator regression
// Drives directed corner requests and then phases of random requests under
// changing register settings, with random gaps on the request side and random
// stalls on the grant side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module descriptor_slot_allocator_test;
  import dsa_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED   = 2'd3;
  localparam int unsigned     RANDOM_PHASES = 8;
  localparam int unsigned     PHASE_ITEMS   = 190;
  localparam int unsigned     SETTLE_CYCLES = 12;
  localparam int unsigned     STUCK_LIMIT   = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 req_valid;
  logic                 req_stall;
  logic [OP_W-1:0]      operation;
  logic [SLOT_W-1:0]    free_slot;
  logic                 handle_valid;
  logic [FENCE_W-1:0]   fence_done;
  logic [FENCE_W-1:0]   fence_now;
  logic                 grant_valid;
  logic                 grant_stall;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic [ADDR_W-1:0]    cpu_address;
  logic [ADDR_W-1:0]    gpu_address;
  int unsigned          fail_count;
  int unsigned          pending;

  int unsigned          stuck_cycles = 0;
  int unsigned          request_count = 0;
  int unsigned          grant_count = 0;
  int unsigned          cur_pcount = 0;
  logic                 quiet_requests = 1'b0;
  logic                 quiet_grants = 1'b0;
  logic [FENCE_W-1:0]   frame_now;

  descriptor_slot_allocator DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (req_valid),
    .in_stall_o          (req_stall),
    .operation_i         (operation),
    .free_slot_i         (free_slot),
    .free_handle_valid_i (handle_valid),
    .fence_completed_i   (fence_done),
    .fence_current_i     (fence_now),
    .out_valid_o         (grant_valid),
    .out_stall_i         (grant_stall),
    .status_o            (status),
    .slot_o              (slot),
    .cpu_address_o       (cpu_address),
    .gpu_address_o       (gpu_address)
  );

  descriptor_slot_allocator_checker grant_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (req_valid),
    .in_stall_i          (req_stall),
    .operation_i         (operation),
    .free_slot_i         (free_slot),
    .free_handle_valid_i (handle_valid),
    .fence_completed_i   (fence_done),
    .fence_current_i     (fence_now),
    .out_valid_i         (grant_valid),
    .out_stall_i         (grant_stall),
    .status_i            (status),
    .slot_i              (slot),
    .cpu_address_i       (cpu_address),
    .gpu_address_i       (gpu_address),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (grant_valid && !grant_stall) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Grant side: hold stall for a random count, then take one grant.
  initial begin
    int unsigned hold;
    grant_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = quiet_grants ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        grant_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      grant_stall <= 1'b0;
      @(posedge clk);
      while (!(grant_valid && !grant_stall)) @(posedge clk);
      grant_count++;
      if (grant_count % 40 == 0) quiet_grants = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic issue_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] fslot, logic hv,
                               logic [FENCE_W-1:0] done, logic [FENCE_W-1:0] now);
    int unsigned gap;
    gap = quiet_requests ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation    <= op;
    free_slot    <= fslot;
    handle_valid <= hv;
    fence_done   <= done;
    fence_now    <= now;
    req_valid    <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    request_count++;
    if (request_count % 50 == 0) quiet_requests = ($urandom_range(0, 3) == 0);
  endtask

  // Drop the request line, drain all grants and let a reserved request finish.
  task automatic quiesce();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic program_allocator(logic [COUNT_W-1:0] pc, logic [COUNT_W-1:0] tc,
                                   logic [STRIDE_W-1:0] stride, logic [ADDR_W-1:0] cbase,
                                   logic [ADDR_W-1:0] gbase, logic vis);
    logic [CFG_W-1:0] junk;
    junk = {$urandom, $urandom};
    // upper data bits above a count are don't-care; fill them with noise
    write_register(REG_PCOUNT, {junk[CFG_W-1:COUNT_W], pc});
    write_register(REG_TCOUNT, {junk[COUNT_W +: CFG_W-COUNT_W], tc});
    write_register(REG_STRIDE, CFG_W'(stride));
    write_register(REG_CPU_BASE, cbase);
    write_register(REG_GPU_BASE, gbase);
    write_register(REG_VISIBLE, CFG_W'(vis));
    cfg_we <= 1'b0;
    cur_pcount = 32'(pc);
  endtask

  task automatic issue_random_request();
    int unsigned        pick;
    int unsigned        lag;
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  fslot;
    logic               hv;
    logic [FENCE_W-1:0] done;
    logic [FENCE_W-1:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_ALLOC_P;
    else if (pick < 55) op = OP_FREE_P;
    else if (pick < 96) op = OP_ALLOC_T;
    else                op = OP_RESERVED;
    // mostly return slots from the persistent range, sometimes anything
    if (cur_pcount != 0 && $urandom_range(0, 4) != 0)
      fslot = SLOT_W'($urandom_range(0, cur_pcount - 1));
    else
      fslot = SLOT_W'($urandom);
    hv = ($urandom_range(0, 9) != 0);
    // advance the frame now and then; completion trails it by a few frames
    if ($urandom_range(0, 2) == 0) frame_now++;
    lag  = $urandom_range(0, 3);
    done = (frame_now >= FENCE_W'(lag)) ? frame_now - FENCE_W'(lag) : '0;
    now  = frame_now;
    if ($urandom_range(0, 19) == 0) begin
      done = {$urandom, $urandom};
      now  = {$urandom, $urandom};
    end
    issue_request(op, fslot, hv, done, now);
    if ($urandom_range(0, 79) == 0) begin
      req_valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_valid    = 1'b0;
    operation    = '0;
    free_slot    = '0;
    handle_valid = 1'b0;
    fence_done   = '0;
    fence_now    = '0;
    frame_now    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // both rings empty after reset
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_T, '0, 1'b1, '0, '0);
    issue_request(OP_FREE_P, 11'd5, 1'b0, '0, '0);
    issue_request(OP_RESERVED, '1, 1'b1, '1, '1);

    quiesce();
    program_allocator(11'd2, 11'd2, 11'd1024, '1, {$urandom, $urandom}, 1'b1);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);
    issue_request(OP_FREE_P, '1, 1'b1, '0, '0);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_T, '0, 1'b1, 64'd0, 64'd5);
    issue_request(OP_ALLOC_T, '0, 1'b1, 64'd0, 64'd5);
    // release head still younger than the completed fence
    issue_request(OP_ALLOC_T, '0, 1'b1, 64'd4, 64'd6);
    issue_request(OP_ALLOC_T, '0, 1'b1, 64'd5, '1);
    issue_request(OP_ALLOC_T, '0, 1'b1, '1, 64'd0);
    issue_request(OP_ALLOC_T, '0, 1'b1, '1, 64'd0);

    // persistent ring full on a valid free
    quiesce();
    program_allocator(11'd1024, 11'd0, 11'd1, '0, '1, 1'b0);
    issue_request(OP_FREE_P, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);

    // oversized persistent count: ring saturates, temporary numbers wrap
    quiesce();
    program_allocator(11'd2047, 11'd3, 11'd1024, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'b1);
    repeat (4) issue_request(OP_ALLOC_T, '0, 1'b1, '0, '0);
    issue_request(OP_ALLOC_P, '0, 1'b1, '0, '0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiesce();
      case (phase)
        0: program_allocator(11'd3, 11'd2, 11'd32, {$urandom, $urandom},
                             {$urandom, $urandom}, 1'b1);
        1: program_allocator(11'd0, 11'd1024, 11'd1, '1, '1, 1'b1);
        2: program_allocator(11'd1024, 11'd0, 11'd1024, '0, '0, 1'b0);
        3: program_allocator(11'd1024, 11'd1024, STRIDE_W'($urandom_range(1, 1024)),
                             {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        default: program_allocator(COUNT_W'($urandom_range(0, 16)),
                                   COUNT_W'($urandom_range(1, 12)),
                                   STRIDE_W'($urandom_range(1, 1024)),
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   1'($urandom));
      endcase
      // one phase runs its fences right below the top of the range
      frame_now = (phase == 5) ? 64'hFFFF_FFFF_FFFF_FF80 : FENCE_W'($urandom_range(0, 100));
      repeat (PHASE_ITEMS) issue_random_request();
    end

    quiesce();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/dsa_pkg.sv
design/dsa_ram.sv
design/dsa_free_list.sv
design/descriptor_slot_allocator.sv
bench/descriptor_slot_allocator_checker.sv
bench/descriptor_slot_allocator_test.sv
